[hw/rtl/assert_macros.svh]
// Assertion macros used by the top level of the stereo FIR RTL.
// Depends on nothing; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SFSG_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sfsg assertion failed");

// Next-cycle implication, disabled during reset.
`define SFSG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfsg assertion failed");

`endif

[hw/rtl/sfsg_pkg.sv]
// Package for the stereo FIR with channel swap and gain: sizes, codes and
// the control word shared between the sequencer and the MAC lanes.
// Depends on nothing.
package sfsg_pkg;

  // Filter length and the widths that follow from it.
  localparam int TAP_COUNT = 128;
  localparam int TAP_AW    = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
  localparam int CNT_W     = $clog2(TAP_COUNT + 1);
  localparam int ACC_W     = 32 + $clog2(TAP_COUNT);

  // Sample, tap and gain formats.
  localparam int SAMPLE_W    = 16;
  localparam int GAIN_W      = 16;
  localparam int MUL_W       = ACC_W + GAIN_W + 1;
  localparam int SCALE_SHIFT = 27;
  localparam int Q_W         = MUL_W - SCALE_SHIFT;

  // APB register map.
  localparam int APB_AW = 3;
  localparam logic REG_SWAP = 1'b0;
  localparam logic REG_GAIN = 1'b1;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;

  // Request codes.
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;
  localparam logic SIDE_LEFT  = 1'b0;
  localparam logic SIDE_RIGHT = 1'b1;

  // Control word from the sequencer to the lanes.
  typedef struct packed {
    logic              wr;     // push a new sample into the delay lines
    logic              issue;  // read one tap position this cycle
    logic              last;   // this is the final tap position
    logic [TAP_AW-1:0] idx;    // tap position (age of the sample)
  } ctl_t;

endpackage

[hw/rtl/sfsg_if.sv]
// Valid/ready channel interfaces for request words and result words.
// Depends on sfsg_pkg.
interface sfsg_req_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  req_type;
  logic                                  tap_side;
  logic [6:0]                            tap_index;
  logic signed [sfsg_pkg::SAMPLE_W-1:0]  tap_value;
  logic signed [sfsg_pkg::SAMPLE_W-1:0]  sample_left;
  logic signed [sfsg_pkg::SAMPLE_W-1:0]  sample_right;

  modport source (output valid, req_type, tap_side, tap_index, tap_value,
                  sample_left, sample_right, input ready);
  modport sink   (input valid, req_type, tap_side, tap_index, tap_value,
                  sample_left, sample_right, output ready);
endinterface

interface sfsg_res_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [sfsg_pkg::SAMPLE_W-1:0]  out_left;
  logic signed [sfsg_pkg::SAMPLE_W-1:0]  out_right;
  logic                                  clipped;

  modport source (output valid, out_left, out_right, clipped, input ready);
  modport sink   (input valid, out_left, out_right, clipped, output ready);
endinterface

[hw/rtl/sfsg_taps.sv]
// Tap bank: left-ear and right-ear coefficient memories with per-entry
// valid bits, one read per cycle, and the channel swap select.
// Depends on sfsg_pkg.
module sfsg_taps (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 we,
  input  logic                                 side,
  input  logic [6:0]                           index,
  input  logic signed [sfsg_pkg::SAMPLE_W-1:0] value,
  input  logic [sfsg_pkg::TAP_AW-1:0]          rd_idx,
  input  logic                                 swap,
  output logic signed [sfsg_pkg::SAMPLE_W-1:0] tap_a,
  output logic signed [sfsg_pkg::SAMPLE_W-1:0] tap_b
);

  logic signed [sfsg_pkg::SAMPLE_W-1:0] mem_l [sfsg_pkg::TAP_COUNT];
  logic signed [sfsg_pkg::SAMPLE_W-1:0] mem_r [sfsg_pkg::TAP_COUNT];
  logic [sfsg_pkg::TAP_COUNT-1:0]       valid_l;
  logic [sfsg_pkg::TAP_COUNT-1:0]       valid_r;
  logic signed [sfsg_pkg::SAMPLE_W-1:0] rd_l;
  logic signed [sfsg_pkg::SAMPLE_W-1:0] rd_r;
  logic                                 ok_l;
  logic                                 ok_r;
  logic                                 in_range;
  logic [sfsg_pkg::TAP_AW-1:0]          wr_addr;
  logic signed [sfsg_pkg::SAMPLE_W-1:0] val_l;
  logic signed [sfsg_pkg::SAMPLE_W-1:0] val_r;

  // A load beyond the filter length is dropped.
  assign in_range = (32'(index) < sfsg_pkg::TAP_COUNT);
  assign wr_addr  = sfsg_pkg::TAP_AW'(index);

  // Coefficient memories: one write port, one registered read port each.
  always_ff @(posedge clk) begin
    if (we && in_range && side == sfsg_pkg::SIDE_LEFT) begin
      mem_l[wr_addr] <= value;
    end
    if (we && in_range && side == sfsg_pkg::SIDE_RIGHT) begin
      mem_r[wr_addr] <= value;
    end
    rd_l <= mem_l[rd_idx];
    rd_r <= mem_r[rd_idx];
  end

  // Valid bits make unwritten taps read as zero after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_l <= '0;
      valid_r <= '0;
      ok_l    <= 1'b0;
      ok_r    <= 1'b0;
    end else begin
      if (we && in_range && side == sfsg_pkg::SIDE_LEFT) begin
        valid_l[wr_addr] <= 1'b1;
      end
      if (we && in_range && side == sfsg_pkg::SIDE_RIGHT) begin
        valid_r[wr_addr] <= 1'b1;
      end
      ok_l <= valid_l[rd_idx];
      ok_r <= valid_r[rd_idx];
    end
  end

  // Mask, then route each ear's taps to the lane that uses them.
  assign val_l = ok_l ? rd_l : '0;
  assign val_r = ok_r ? rd_r : '0;
  assign tap_a = swap ? val_r : val_l;
  assign tap_b = swap ? val_l : val_r;

endmodule

[hw/rtl/sfsg_lane.sv]
// One MAC lane: circular delay line in a memory, a fill count for the
// zero history after reset, and a multiply-accumulate pipeline.
// Depends on sfsg_pkg.
module sfsg_lane (
  input  logic                                 clk,
  input  logic                                 rst,
  input  sfsg_pkg::ctl_t                       ctl,
  input  logic signed [sfsg_pkg::SAMPLE_W-1:0] sample,
  input  logic signed [sfsg_pkg::SAMPLE_W-1:0] tap,
  output logic signed [sfsg_pkg::ACC_W-1:0]    acc,
  output logic                                 done
);

  logic signed [sfsg_pkg::SAMPLE_W-1:0] hist_mem [sfsg_pkg::TAP_COUNT];
  logic [sfsg_pkg::TAP_AW-1:0]          wr_ptr;
  logic [sfsg_pkg::TAP_AW-1:0]          rd_ptr;
  logic [sfsg_pkg::CNT_W-1:0]           fill;
  logic signed [sfsg_pkg::SAMPLE_W-1:0] hist_rd;
  logic signed [sfsg_pkg::SAMPLE_W-1:0] hist_val;
  logic                                 hist_ok;
  logic                                 v1;
  logic                                 last1;
  logic                                 v2;
  logic                                 last2;
  logic signed [31:0]                   prod;

  // Delay-line memory: written on a new sample, read one age per cycle.
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      hist_mem[wr_ptr] <= sample;
    end
    hist_rd <= hist_mem[rd_ptr];
  end

  // Pointers, fill count and pipeline valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      fill    <= '0;
      hist_ok <= 1'b0;
      v1      <= 1'b0;
      last1   <= 1'b0;
      v2      <= 1'b0;
      last2   <= 1'b0;
      done    <= 1'b0;
    end else begin
      if (ctl.wr) begin
        // The newest sample sits at the slot written now.
        rd_ptr <= wr_ptr;
        if (wr_ptr == sfsg_pkg::TAP_AW'(sfsg_pkg::TAP_COUNT - 1)) begin
          wr_ptr <= '0;
        end else begin
          wr_ptr <= wr_ptr + sfsg_pkg::TAP_AW'(1);
        end
        if (fill != sfsg_pkg::CNT_W'(sfsg_pkg::TAP_COUNT)) begin
          fill <= fill + sfsg_pkg::CNT_W'(1);
        end
      end else if (ctl.issue) begin
        // Step back one sample in age, wrapping around the ring.
        if (rd_ptr == '0) begin
          rd_ptr <= sfsg_pkg::TAP_AW'(sfsg_pkg::TAP_COUNT - 1);
        end else begin
          rd_ptr <= rd_ptr - sfsg_pkg::TAP_AW'(1);
        end
      end
      // Samples older than the fill count are still the reset zeros.
      hist_ok <= (sfsg_pkg::CNT_W'(ctl.idx) < fill);
      v1      <= ctl.issue;
      last1   <= ctl.issue && ctl.last;
      v2      <= v1;
      last2   <= last1;
      done    <= v2 && last2;
    end
  end

  assign hist_val = hist_ok ? hist_rd : '0;

  // Multiply stage, then accumulate; a new sample clears the sum.
  always_ff @(posedge clk) begin
    prod <= 32'(hist_val) * 32'(tap);
    if (ctl.wr) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + sfsg_pkg::ACC_W'(prod);
    end
  end

endmodule

[hw/rtl/sfsg_merge.sv]
// Merge stage: scales both lane sums by the Q4.12 gain, rounds, saturates,
// combines the clip flags and holds the result word for the consumer.
// Depends on sfsg_pkg and sfsg_if.
module sfsg_merge (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                done,
  input  logic signed [sfsg_pkg::ACC_W-1:0]   acc_l,
  input  logic signed [sfsg_pkg::ACC_W-1:0]   acc_r,
  input  logic [sfsg_pkg::GAIN_W-1:0]         gain,
  output logic                                res_load,
  sfsg_res_if.source                          res
);

  logic signed [sfsg_pkg::MUL_W-1:0]    mul_l;
  logic signed [sfsg_pkg::MUL_W-1:0]    mul_r;
  logic                                 mul_v;
  logic signed [sfsg_pkg::MUL_W-1:0]    rnd_l;
  logic signed [sfsg_pkg::MUL_W-1:0]    rnd_r;
  logic signed [sfsg_pkg::Q_W-1:0]      q_l;
  logic signed [sfsg_pkg::Q_W-1:0]      q_r;
  logic                                 fit_l;
  logic                                 fit_r;
  logic signed [sfsg_pkg::SAMPLE_W-1:0] sat_l;
  logic signed [sfsg_pkg::SAMPLE_W-1:0] sat_r;
  logic signed [sfsg_pkg::MUL_W-1:0]    gain_s;
  logic signed [sfsg_pkg::MUL_W-1:0]    round_bias;

  assign gain_s     = sfsg_pkg::MUL_W'($signed({1'b0, gain}));
  assign round_bias = sfsg_pkg::MUL_W'(1) <<< (sfsg_pkg::SCALE_SHIFT - 1);

  // Gain multiply, registered; held until the output register is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_v <= 1'b0;
    end else if (done) begin
      mul_v <= 1'b1;
    end else if (res_load) begin
      mul_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      mul_l <= sfsg_pkg::MUL_W'(acc_l) * gain_s;
      mul_r <= sfsg_pkg::MUL_W'(acc_r) * gain_s;
    end
  end

  // Round half up, drop the fraction, and clamp to 16 bits.
  assign rnd_l = mul_l + round_bias;
  assign rnd_r = mul_r + round_bias;
  assign q_l   = rnd_l[sfsg_pkg::MUL_W-1:sfsg_pkg::SCALE_SHIFT];
  assign q_r   = rnd_r[sfsg_pkg::MUL_W-1:sfsg_pkg::SCALE_SHIFT];
  assign fit_l = (q_l[sfsg_pkg::Q_W-1:sfsg_pkg::SAMPLE_W-1]
                  == {(sfsg_pkg::Q_W-sfsg_pkg::SAMPLE_W+1){q_l[sfsg_pkg::Q_W-1]}});
  assign fit_r = (q_r[sfsg_pkg::Q_W-1:sfsg_pkg::SAMPLE_W-1]
                  == {(sfsg_pkg::Q_W-sfsg_pkg::SAMPLE_W+1){q_r[sfsg_pkg::Q_W-1]}});

  always_comb begin
    if (fit_l) begin
      sat_l = q_l[sfsg_pkg::SAMPLE_W-1:0];
    end else if (q_l[sfsg_pkg::Q_W-1]) begin
      sat_l = {1'b1, {(sfsg_pkg::SAMPLE_W-1){1'b0}}};
    end else begin
      sat_l = {1'b0, {(sfsg_pkg::SAMPLE_W-1){1'b1}}};
    end
    if (fit_r) begin
      sat_r = q_r[sfsg_pkg::SAMPLE_W-1:0];
    end else if (q_r[sfsg_pkg::Q_W-1]) begin
      sat_r = {1'b1, {(sfsg_pkg::SAMPLE_W-1){1'b0}}};
    end else begin
      sat_r = {1'b0, {(sfsg_pkg::SAMPLE_W-1){1'b1}}};
    end
  end

  // Output register: loads when empty or when the held word is taken.
  assign res_load = mul_v && (!res.valid || res.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (res_load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res.out_left  <= sat_l;
      res.out_right <= sat_r;
      res.clipped   <= !fit_l || !fit_r;
    end
  end

endmodule

[hw/rtl/stereo_fir_swap_gain.sv]
// Top level of the stereo FIR with channel swap and gain: APB registers,
// tap-position sequencer, tap bank, two MAC lanes and the merge stage.
// Depends on sfsg_pkg, sfsg_if, sfsg_taps, sfsg_lane, sfsg_merge.
//
//   Port   Kind        Moves
//   req    valid/ready request word: tap load or stereo sample
//   res    valid/ready result word: left, right, clip flag
//   apb    APB write   swap_channels at 0x0, gain_linear at 0x4
//
// A tap load leaves the sequencer idle. After a stereo sample, the next accept
// waits for its result to load the output register. The two lanes step one
// tap position per cycle on their single delay-line and coefficient read ports.
// A result waiting in the output register does not block the next request
// unless a second result is ready before the first is taken.
// Reset is synchronous; taps and delay lines read as zero afterwards at once.
`include "assert_macros.svh"

module stereo_fir_swap_gain (
  input  logic                         clk,
  input  logic                         rst,
  sfsg_req_if.sink                     req,
  sfsg_res_if.source                   res,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sfsg_pkg::APB_AW-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT
  } state_t;

  state_t                               state;
  logic [sfsg_pkg::TAP_AW-1:0]          cnt;
  logic                                 swap_channels;
  logic [sfsg_pkg::GAIN_W-1:0]          gain_linear;
  logic                                 accept;
  logic                                 cfg_we;
  logic                                 reg_idx;
  sfsg_pkg::ctl_t                       ctl;
  logic signed [sfsg_pkg::SAMPLE_W-1:0] tap_a;
  logic signed [sfsg_pkg::SAMPLE_W-1:0] tap_b;
  logic signed [sfsg_pkg::ACC_W-1:0]    acc_l;
  logic signed [sfsg_pkg::ACC_W-1:0]    acc_r;
  logic                                 done_l;
  logic                                 done_r;
  logic                                 res_load;
  logic                                 tap_we;

  // Configuration registers.
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      swap_channels <= 1'b0;
      gain_linear   <= sfsg_pkg::GAIN_RESET;
    end else if (cfg_we) begin
      case (reg_idx)
        sfsg_pkg::REG_SWAP: swap_channels <= pwdata[0];
        sfsg_pkg::REG_GAIN: gain_linear   <= pwdata[sfsg_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      sfsg_pkg::REG_SWAP: prdata = 32'(swap_channels);
      sfsg_pkg::REG_GAIN: prdata = 32'(gain_linear);
      default:            prdata = '0;
    endcase
  end

  // Request handshake and control word.
  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign tap_we    = accept && req.req_type == sfsg_pkg::REQ_LOAD;

  assign ctl.wr    = accept && req.req_type == sfsg_pkg::REQ_SAMPLE;
  assign ctl.issue = (state == ST_RUN);
  assign ctl.last  = (cnt == sfsg_pkg::TAP_AW'(sfsg_pkg::TAP_COUNT - 1));
  assign ctl.idx   = cnt;

  // Sequencer: walk the tap positions, then wait for the merge stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (ctl.wr) begin
            state <= ST_RUN;
            cnt   <= '0;
          end
        end
        ST_RUN: begin
          if (ctl.last) begin
            state <= ST_WAIT;
          end else begin
            cnt <= cnt + sfsg_pkg::TAP_AW'(1);
          end
        end
        ST_WAIT: begin
          if (res_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  sfsg_taps u_taps (
    .clk    (clk),
    .rst    (rst),
    .we     (tap_we),
    .side   (req.tap_side),
    .index  (req.tap_index),
    .value  (req.tap_value),
    .rd_idx (cnt),
    .swap   (swap_channels),
    .tap_a  (tap_a),
    .tap_b  (tap_b)
  );

  sfsg_lane u_lane_l (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .sample (req.sample_left),
    .tap    (tap_a),
    .acc    (acc_l),
    .done   (done_l)
  );

  sfsg_lane u_lane_r (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .sample (req.sample_right),
    .tap    (tap_b),
    .acc    (acc_r),
    .done   (done_r)
  );

  sfsg_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .done     (done_l),
    .acc_l    (acc_l),
    .acc_r    (acc_r),
    .gain     (gain_linear),
    .res_load (res_load),
    .res      (res)
  );

  // Checks on the sequencer and the lanes.
  `SFSG_ASSERT_NEXT(a_sample_starts_run, clk, rst, ctl.wr, state == ST_RUN && cnt == '0)
  `SFSG_ASSERT_IMPL(a_lanes_in_step, clk, rst, 1'b1, done_l == done_r)
  `SFSG_ASSERT_IMPL(a_done_in_wait, clk, rst, done_l, state == ST_WAIT)
  `SFSG_ASSERT_IMPL(a_load_only_in_wait, clk, rst, res_load, state == ST_WAIT)

endmodule

[tb/tb_stereo_fir_swap_gain.sv]
`timescale 1ns / 100ps
// Self-checking testbench for stereo_fir_swap_gain: tap loads, stereo samples,
// channel swap and Q4.12 gain, with random idling on both channels.
// Depends on sfsg_pkg, sfsg_if and the stereo_fir_swap_gain RTL.

module tb_stereo_fir_swap_gain;
  import sfsg_pkg::*;

  // Time for a sample word to pass through, with margin on top of that.
  localparam int DRAIN_CYCLES = TAP_COUNT + 20;

  typedef struct {
    bit               req_type;
    bit               tap_side;
    bit [6:0]         tap_index;
    bit signed [15:0] tap_value;
    bit signed [15:0] sample_left;
    bit signed [15:0] sample_right;
  } fir_request_t;

  typedef struct {
    logic signed [15:0] out_left;
    logic signed [15:0] out_right;
    logic               clipped;
  } fir_output_t;

  // Tracks taps, delay lines and registers, and queues the expected output words.
  class binaural_fir_tracker;
    bit signed [15:0] taps_left  [TAP_COUNT];
    bit signed [15:0] taps_right [TAP_COUNT];
    bit signed [15:0] hist_left  [TAP_COUNT];
    bit signed [15:0] hist_right [TAP_COUNT];
    bit               swap;
    bit [15:0]        gain;
    fir_output_t      pending_outputs[$];
    int               mismatches;
    int               outputs_checked;
    int               loads_seen;
    int               samples_seen;
    int               clips_seen;

    function new();
      swap = 1'b0;
      gain = GAIN_RESET;
    endfunction

    function void write_register(logic idx, bit [31:0] value);
      if (idx == REG_SWAP) begin
        swap = value[0];
      end else if (idx == REG_GAIN) begin
        gain = value[GAIN_W-1:0];
      end
    endfunction

    // Apply the gain, round half up and saturate to 16 bits.
    function bit signed [15:0] scale_and_clip(longint acc, output bit hit);
      longint q;
      q = (acc * longint'(gain) + (longint'(1) <<< (SCALE_SHIFT - 1))) >>> SCALE_SHIFT;
      hit = 1'b0;
      if (q > 32767) begin
        hit = 1'b1;
        return 16'sh7fff;
      end
      if (q < -32768) begin
        hit = 1'b1;
        return 16'sh8000;
      end
      return q[15:0];
    endfunction

    // Update the state for one accepted request word.
    function void take_request(fir_request_t r);
      longint      acc_l;
      longint      acc_r;
      bit          clip_l;
      bit          clip_r;
      fir_output_t y;
      if (r.req_type == REQ_LOAD) begin
        loads_seen++;
        if (r.tap_index < TAP_COUNT) begin
          if (r.tap_side == SIDE_LEFT) taps_left[r.tap_index] = r.tap_value;
          else taps_right[r.tap_index] = r.tap_value;
        end
        return;
      end
      samples_seen++;
      for (int k = TAP_COUNT - 1; k > 0; k--) begin
        hist_left[k]  = hist_left[k-1];
        hist_right[k] = hist_right[k-1];
      end
      hist_left[0]  = r.sample_left;
      hist_right[0] = r.sample_right;
      acc_l = 0;
      acc_r = 0;
      for (int k = 0; k < TAP_COUNT; k++) begin
        acc_l += longint'(hist_left[k]) * longint'(swap ? taps_right[k] : taps_left[k]);
        acc_r += longint'(hist_right[k]) * longint'(swap ? taps_left[k] : taps_right[k]);
      end
      y.out_left  = scale_and_clip(acc_l, clip_l);
      y.out_right = scale_and_clip(acc_r, clip_r);
      y.clipped   = clip_l | clip_r;
      pending_outputs.push_back(y);
    endfunction

    // Compare one accepted output word with the oldest expectation.
    function void check_output(fir_output_t got);
      fir_output_t want;
      if (pending_outputs.size() == 0) begin
        $display("%0t: unexpected output word, left %0d right %0d clipped %0b",
                 $time, got.out_left, got.out_right, got.clipped);
        mismatches++;
        return;
      end
      want = pending_outputs.pop_front();
      outputs_checked++;
      if (want.clipped) clips_seen++;
      if (got.out_left !== want.out_left) begin
        $display("%0t: out_left mismatch, expected %0d, got %0d",
                 $time, want.out_left, got.out_left);
        mismatches++;
      end
      if (got.out_right !== want.out_right) begin
        $display("%0t: out_right mismatch, expected %0d, got %0d",
                 $time, want.out_right, got.out_right);
        mismatches++;
      end
      if (got.clipped !== want.clipped) begin
        $display("%0t: clipped mismatch, expected %0b, got %0b",
                 $time, want.clipped, got.clipped);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  bit                  no_gaps;
  int                  settings_run;
  binaural_fir_tracker tracker = new();

  sfsg_req_if req_ch ();
  sfsg_res_if res_ch ();

  stereo_fir_swap_gain DUT (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Random level: mostly within +/- 2^amp_bits, with full-scale values mixed in.
  function automatic bit signed [15:0] random_level(int amp_bits);
    bit signed [15:0] v;
    int unsigned      span;
    case ($urandom_range(0, 15))
      0: v = 16'sh7fff;
      1: v = 16'sh8000;
      2, 3: v = 16'($urandom());
      default: begin
        span = 1 << amp_bits;
        v = 16'($urandom_range(0, 2 * span - 1) - span);
      end
    endcase
    return v;
  endfunction

  // Every field is random; the fields that the word type ignores are too.
  function automatic fir_request_t random_request(int load_pct, int amp_bits);
    fir_request_t r;
    r.req_type     = ($urandom_range(0, 99) < load_pct) ? REQ_LOAD : REQ_SAMPLE;
    r.tap_side     = 1'($urandom_range(0, 1));
    r.tap_index    = 7'($urandom_range(0, 127));
    r.tap_value    = random_level(12);
    r.sample_left  = random_level(amp_bits);
    r.sample_right = random_level(amp_bits);
    return r;
  endfunction

  function automatic fir_request_t make_load(logic side, int idx, bit signed [15:0] val);
    fir_request_t r;
    r.req_type     = REQ_LOAD;
    r.tap_side     = side;
    r.tap_index    = 7'(idx);
    r.tap_value    = val;
    r.sample_left  = 16'sh7fff;
    r.sample_right = 16'sh8000;
    return r;
  endfunction

  function automatic fir_request_t make_sample(bit signed [15:0] left, bit signed [15:0] right);
    fir_request_t r;
    r.req_type     = REQ_SAMPLE;
    r.tap_side     = SIDE_RIGHT;
    r.tap_index    = 7'h7f;
    r.tap_value    = 16'sh5a5a;
    r.sample_left  = left;
    r.sample_right = right;
    return r;
  endfunction

  // Offer one request word after a random gap and wait until it is taken.
  task automatic send_request(fir_request_t r);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= r.req_type;
    req_ch.tap_side     <= r.tap_side;
    req_ch.tap_index    <= r.tap_index;
    req_ch.tap_value    <= r.tap_value;
    req_ch.sample_left  <= r.sample_left;
    req_ch.sample_right <= r.sample_right;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    tracker.take_request(r);
  endtask

  task automatic run_random(int count, int load_pct, int amp_bits);
    for (int i = 0; i < count; i++) send_request(random_request(load_pct, amp_bits));
  endtask

  // Let every expected output word drain, then let a trailing load finish.
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (tracker.pending_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write with random junk in the bits above the register width.
  task automatic apb_write(logic idx, int unsigned value);
    bit [31:0] mask;
    bit [31:0] word;
    mask = (idx == REG_SWAP) ? 32'h1 : 32'hffff;
    word = ($urandom() & ~mask) | (value & mask);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.write_register(idx, word);
  endtask

  // Output side: random stall before each word, then check it.
  initial begin
    int          stall;
    fir_output_t got;
    res_ch.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (res_ch.valid !== 1'b1);
      got.out_left  = res_ch.out_left;
      got.out_right = res_ch.out_right;
      got.clipped   = res_ch.clipped;
      tracker.check_output(got);
    end
  end

  // Main sequence: directed words, then random phases under several settings.
  initial begin
    int phase_swap [6];
    int phase_gain [6];
    int phase_amp  [6];
    int sw;
    int g;
    int a;
    phase_swap          = '{1, 0, 1, 1, 0, 0};
    phase_gain          = '{65535, 0, 4096, 1, 2048, 0};
    phase_amp           = '{12, 8, 4, 15, 7, 0};
    rst                 <= 1'b1;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    req_ch.valid        <= 1'b0;
    req_ch.req_type     <= REQ_LOAD;
    req_ch.tap_side     <= SIDE_LEFT;
    req_ch.tap_index    <= '0;
    req_ch.tap_value    <= '0;
    req_ch.sample_left  <= '0;
    req_ch.sample_right <= '0;
    no_gaps             = 1'b0;
    settings_run        = 1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Zero taps after reset give silence even for full-scale input.
    send_request(make_sample(16'sh7fff, 16'sh8000));
    // Extreme taps at both ends of each impulse response.
    send_request(make_load(SIDE_LEFT, 0, 16'sh7fff));
    send_request(make_load(SIDE_RIGHT, 0, 16'sh8000));
    send_request(make_load(SIDE_LEFT, 127, 16'sh8000));
    send_request(make_load(SIDE_RIGHT, 127, 16'sh7fff));
    send_request(make_load(SIDE_LEFT, 1, 16'sh0001));
    send_request(make_load(SIDE_RIGHT, 2, 16'sh4000));
    // Full-scale samples: the min times min product clips.
    send_request(make_sample(16'sh7fff, 16'sh8000));
    send_request(make_sample(16'sh8000, 16'sh7fff));
    send_request(make_sample(16'sh8000, 16'sh8000));
    send_request(make_sample(16'sh7fff, 16'sh7fff));
    send_request(make_sample(16'sh0000, 16'sh0000));
    send_request(make_sample(16'sh0001, 16'shffff));
    // A lone one or minus one reaching the 0.5 tap lands exactly on a half.
    send_request(make_sample(16'sh0000, 16'sh0001));
    send_request(make_sample(16'sh0000, 16'sh0000));
    send_request(make_sample(16'sh0000, 16'sh0000));
    send_request(make_sample(16'sh0000, 16'shffff));
    send_request(make_sample(16'sh0000, 16'sh0000));
    send_request(make_sample(16'sh0000, 16'sh0000));

    run_random(150, 30, 6);

    for (int p = 0; p < 6; p++) begin
      settle();
      sw = phase_swap[p];
      g  = phase_gain[p];
      a  = phase_amp[p];
      if (p == 5) begin
        sw = $urandom_range(0, 1);
        g  = $urandom_range(0, 65535);
        a  = $urandom_range(3, 15);
      end
      apb_write(REG_SWAP, sw);
      apb_write(REG_GAIN, g);
      settings_run++;
      no_gaps = (p == 1 || p == 4);
      run_random(175, 30, a);
    end

    settle();
    $display("Checked %0d output words from %0d samples and %0d tap loads; %0d clipped.",
             tracker.outputs_checked, tracker.samples_seen, tracker.loads_seen,
             tracker.clips_seen);
    $display("Covered %0d register settings, both channel orders, gain from 0 to 65535.",
             settings_run);
    if (tracker.mismatches == 0 && tracker.pending_outputs.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[stereo_fir_swap_gain.f]
+incdir+hw/rtl
hw/rtl/sfsg_pkg.sv
hw/rtl/sfsg_if.sv
hw/rtl/sfsg_taps.sv
hw/rtl/sfsg_lane.sv
hw/rtl/sfsg_merge.sv
hw/rtl/stereo_fir_swap_gain.sv
tb/tb_stereo_fir_swap_gain.sv
